/* design/sobel_pkg.sv */
// Shared types, constants and helpers for the Sobel edge stream block.
package sobel_pkg;

    localparam int GRAY_W     = 8;
    localparam int RGB_W      = 24;
    localparam int MAG_W      = 11;
    localparam int ITEM_W     = 23;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int THR_W      = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [FW_W-1:0]  FW_RESET  = 11'd512;
    localparam logic [FH_W-1:0]  FH_RESET  = 13'd512;
    localparam logic [THR_W-1:0] THR_RESET = 11'd1;

    localparam logic [15:0] W_RED   = 16'd77;
    localparam logic [15:0] W_GREEN = 16'd151;
    localparam logic [15:0] W_BLUE  = 16'd28;

    typedef struct packed {
        logic [RGB_W-1:0] pixel_rgb;
        logic             is_fill;
    } pix_t;

    typedef struct packed {
        logic             out_valid;
        logic [MAG_W-1:0] magnitude;
        logic             on_border;
        logic             edge_res;
        logic             frame_last;
    } res_t;

    typedef struct packed {
        logic [GRAY_W-1:0] lt;
        logic [GRAY_W-1:0] lm;
        logic [GRAY_W-1:0] lb;
        logic [GRAY_W-1:0] mt;
        logic [GRAY_W-1:0] mb;
        logic [GRAY_W-1:0] rt;
        logic [GRAY_W-1:0] rm;
        logic [GRAY_W-1:0] rb;
        logic              pix_valid;
        logic              border;
        logic              last;
    } win_t;

    function automatic logic [GRAY_W-1:0] to_gray(input logic [RGB_W-1:0] rgb);
        logic [15:0] s;
        s = W_RED * 16'(rgb[23:16]) + W_GREEN * 16'(rgb[15:8]) + W_BLUE * 16'(rgb[7:0]);
        return s[15:8];
    endfunction

endpackage

/* design/sobel_edge_stream.sv */
// Top level of the streaming 3x3 Sobel edge detector.
// Takes one RGB pixel beat per clock in raster order while pix_stall is low and returns
// one result beat per input beat, describing the pixel one row and one column behind. A
// beat passes through two register stages (window capture, then gradient and result
// register); throughput is one beat per clock while no stall holds the flow, set by the
// single read and single write port of each line store, whose read address is formed
// from the next raster position. After every configuration write the pixel input stalls
// while the line store read is reissued. Line stores need no clearing after reset. Send
// width+1 filler beats after each frame to flush its last rows.
module sobel_edge_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  sobel_pkg::pix_t                   pix,
    output logic                              res_valid,
    input  logic                              res_stall,
    output sobel_pkg::res_t                   res,
    input  logic                              cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int WU_W = $clog2(MAX_WIDTH + 1);

    logic [sobel_pkg::FW_W-1:0]  fw_reg;
    logic [sobel_pkg::FH_W-1:0]  fh_reg;
    logic [sobel_pkg::THR_W-1:0] thr_reg;
    logic                        fresh_reg;
    logic                        s1_valid_reg, s1_valid_next;
    logic                        res_valid_reg, res_valid_next;

    logic [WU_W-1:0]             width_used;
    logic [sobel_pkg::FH_W-1:0]  height_used;
    logic                        take, res_load;
    sobel_pkg::win_t             win;

    always_comb
    begin
        if (32'(fw_reg) < 32'd3)
        begin
            width_used = WU_W'(3);
        end
        else if (32'(fw_reg) > 32'(MAX_WIDTH))
        begin
            width_used = WU_W'(MAX_WIDTH);
        end
        else
        begin
            width_used = WU_W'(fw_reg);
        end

        if (fh_reg < sobel_pkg::FH_W'(3))
        begin
            height_used = sobel_pkg::FH_W'(3);
        end
        else if (32'(fh_reg) > 32'(sobel_pkg::MAX_HEIGHT))
        begin
            height_used = sobel_pkg::FH_W'(sobel_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_used = fh_reg;
        end
    end

    assign res_load       = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign pix_stall      = !(fresh_reg && (!s1_valid_reg || res_load));
    assign take           = pix_valid && !pix_stall;
    assign s1_valid_next  = take || (s1_valid_reg && !res_load);
    assign res_valid_next = res_load || (res_valid_reg && res_stall);
    assign res_valid      = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= sobel_pkg::FW_RESET;
            fh_reg        <= sobel_pkg::FH_RESET;
            thr_reg       <= sobel_pkg::THR_RESET;
            fresh_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= !cfg_we;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sobel_pkg::CFG_FRAME_WIDTH:    fw_reg  <= cfg_data[sobel_pkg::FW_W-1:0];
                    sobel_pkg::CFG_FRAME_HEIGHT:   fh_reg  <= cfg_data[sobel_pkg::FH_W-1:0];
                    sobel_pkg::CFG_EDGE_THRESHOLD: thr_reg <= cfg_data[sobel_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    sobel_line_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_win (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .pix         (pix),
        .width_used  (width_used),
        .height_used (height_used),
        .win         (win)
    );

    sobel_grad u_grad (
        .clk       (clk),
        .load      (res_load),
        .win       (win),
        .threshold (thr_reg),
        .res       (res)
    );

endmodule

/* design/sobel_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/sobel_line_win.sv */
// Gray conversion, line stores, 3x3 window and raster counters.
module sobel_line_win #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  sobel_pkg::pix_t                  pix,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_used,
    input  logic [sobel_pkg::FH_W-1:0]       height_used,
    output sobel_pkg::win_t                  win
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WU_W   = $clog2(MAX_WIDTH + 1);

    function automatic logic [ADDR_W-1:0] col_addr(
        input logic [sobel_pkg::ITEM_W-1:0] p,
        input logic [ADDR_W-1:0]            col,
        input logic [WU_W-1:0]              w
    );
        logic [31:0] c;
        logic        vld;
        vld = 32'(p) >= 32'(w) + 32'd1;
        if (!vld)
        begin
            c = (32'(p) >= 32'(w)) ? 32'd0 : 32'(p);
        end
        else
        begin
            c = 32'(col) + 32'd1;
            if (c >= 32'(w))
            begin
                c = 32'd0;
            end
        end
        if (c >= 32'(MAX_WIDTH))
        begin
            c = 32'd0;
        end
        return c[ADDR_W-1:0];
    endfunction

    logic [sobel_pkg::ITEM_W-1:0] item_reg, item_next;
    logic [ADDR_W-1:0]            col_reg, col_next;
    logic [sobel_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [sobel_pkg::GRAY_W-1:0] wreg_reg [6];
    logic                         hit_reg, hit_next;
    logic [sobel_pkg::GRAY_W-1:0] up_fwd_reg, lo_fwd_reg;
    sobel_pkg::win_t              win_reg;

    logic [sobel_pkg::GRAY_W-1:0] gray, up_q, lo_q, rt, rm;
    logic [ADDR_W-1:0]            waddr, raddr;
    logic                         valid, border, last;

    assign gray  = pix.is_fill ? '0 : sobel_pkg::to_gray(pix.pixel_rgb);
    assign valid = 32'(item_reg) >= 32'(width_used) + 32'd1;
    assign waddr = col_addr(item_reg, col_reg, width_used);
    assign rt    = hit_reg ? up_fwd_reg : up_q;
    assign rm    = hit_reg ? lo_fwd_reg : lo_q;

    always_comb
    begin
        border = valid && (row_reg == '0 || 32'(row_reg) >= 32'(height_used) - 32'd1 ||
                 col_reg == '0 || 32'(col_reg) >= 32'(width_used) - 32'd1);
        last   = valid && 32'(col_reg) >= 32'(width_used) - 32'd1 &&
                 32'(row_reg) >= 32'(height_used) - 32'd1;
        item_next = item_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (take)
        begin
            if (last)
            begin
                item_next = '0;
                col_next  = '0;
                row_next  = '0;
            end
            else
            begin
                item_next = item_reg + 1'b1;
                if (valid)
                begin
                    if (32'(col_reg) + 32'd1 >= 32'(width_used))
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
        end
        raddr    = col_addr(item_next, col_next, width_used);
        hit_next = take && (waddr == raddr);
    end

    sobel_ram #(
        .WIDTH (sobel_pkg::GRAY_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (take),
        .waddr (waddr),
        .wdata (rm),
        .raddr (raddr),
        .rdata (up_q)
    );

    sobel_ram #(
        .WIDTH (sobel_pkg::GRAY_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (take),
        .waddr (waddr),
        .wdata (gray),
        .raddr (raddr),
        .rdata (lo_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            hit_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                wreg_reg[i] <= '0;
            end
        end
        else
        begin
            item_reg <= item_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            hit_reg  <= hit_next;
            if (take)
            begin
                wreg_reg[0] <= wreg_reg[3];
                wreg_reg[1] <= wreg_reg[4];
                wreg_reg[2] <= wreg_reg[5];
                wreg_reg[3] <= rt;
                wreg_reg[4] <= rm;
                wreg_reg[5] <= gray;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        up_fwd_reg <= rm;
        lo_fwd_reg <= gray;
        if (take)
        begin
            win_reg.lt        <= wreg_reg[0];
            win_reg.lm        <= wreg_reg[1];
            win_reg.lb        <= wreg_reg[2];
            win_reg.mt        <= wreg_reg[3];
            win_reg.mb        <= wreg_reg[5];
            win_reg.rt        <= rt;
            win_reg.rm        <= rm;
            win_reg.rb        <= gray;
            win_reg.pix_valid <= valid;
            win_reg.border    <= border;
            win_reg.last      <= last;
        end
    end

    assign win = win_reg;

endmodule

/* design/sobel_grad.sv */
// Sobel gradient magnitude, threshold and result register.
module sobel_grad (
    input  logic                         clk,
    input  logic                         load,
    input  sobel_pkg::win_t              win,
    input  logic [sobel_pkg::THR_W-1:0]  threshold,
    output sobel_pkg::res_t              res
);

    localparam int SUM_W = sobel_pkg::GRAY_W + 2;

    logic [SUM_W-1:0]            sum_r, sum_l, sum_b, sum_t, gx, gy;
    logic [sobel_pkg::MAG_W-1:0] mag;
    sobel_pkg::res_t             res_next, res_reg;

    always_comb
    begin
        sum_r = SUM_W'(win.rt) + {1'b0, win.rm, 1'b0} + SUM_W'(win.rb);
        sum_l = SUM_W'(win.lt) + {1'b0, win.lm, 1'b0} + SUM_W'(win.lb);
        sum_b = SUM_W'(win.lb) + {1'b0, win.mb, 1'b0} + SUM_W'(win.rb);
        sum_t = SUM_W'(win.lt) + {1'b0, win.mt, 1'b0} + SUM_W'(win.rt);
        gx    = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
        gy    = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
        mag   = sobel_pkg::MAG_W'(gx) + sobel_pkg::MAG_W'(gy);

        res_next = '0;
        if (win.pix_valid)
        begin
            res_next.out_valid  = 1'b1;
            res_next.frame_last = win.last;
            if (win.border)
            begin
                res_next.on_border = 1'b1;
                res_next.edge_res  = 1'b1;
            end
            else
            begin
                res_next.magnitude = mag;
                res_next.edge_res  = (mag >= threshold);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
